// File: hw/rtl/cbt_pkg.sv
package cbt_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    // segment count register
    localparam int SEG_W = 6;
    localparam logic [SEG_W-1:0] SEG_RESET = 6'd20;

    // jobs held between the front and the back end
    localparam int Q_DEPTH = 2;

    // packed job: 4 points x 3 axes, segment count, t step quotient, t step remainder
    function automatic int f_job_w(input int coord_w, input int t_frac);
        return 12 * coord_w + 2 * SEG_W + t_frac + 1;
    endfunction

endpackage

// File: hw/rtl/cbt_if.sv
interface cbt_ctl_if import cbt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p0_z;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;
    logic signed [COORD_WIDTH-1:0] p3_x;
    logic signed [COORD_WIDTH-1:0] p3_y;
    logic signed [COORD_WIDTH-1:0] p3_z;

    modport source (
        output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface

interface cbt_curve_if import cbt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] curve_x;
    logic signed [COORD_WIDTH-1:0] curve_y;
    logic signed [COORD_WIDTH-1:0] curve_z;
    logic                          last_point;

    modport source (
        output valid, curve_x, curve_y, curve_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, curve_x, curve_y, curve_z, last_point,
        output ready
    );
endinterface

// File: hw/rtl/cbt_front.sv
module cbt_front import cbt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [SEG_W-1:0]                              i_cfg_data,
    cbt_ctl_if.sink                                       i_ctl,
    output logic                                          o_job_valid,
    input  logic                                          i_job_ready,
    output logic [f_job_w(COORD_WIDTH, T_FRAC_BITS)-1:0]  o_job
);

    localparam int C     = COORD_WIDTH;
    localparam int T     = T_FRAC_BITS;
    localparam int CNT_W = $clog2(T + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    typedef struct packed {
        logic [3:0][2:0][C-1:0] ctl;
        logic [SEG_W-1:0]       segs;
        logic [T:0]             q_step;
        logic [SEG_W-1:0]       r_step;
    } t_job;

    logic [1:0]             r_state;
    logic [SEG_W-1:0]       r_segments;
    logic [SEG_W-1:0]       r_segs_eff;
    logic [3:0][2:0][C-1:0] r_ctl;
    logic [CNT_W-1:0]       r_bit;
    logic [SEG_W-1:0]       r_rem;
    logic [T:0]             r_quo;

    logic [SEG_W:0]         n_shift;
    logic                   n_ge;
    logic [SEG_W-1:0]       n_rem;
    t_job                   job_out;

    assign i_ctl.ready = (r_state == ST_IDLE);
    assign o_job_valid = (r_state == ST_PUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segments <= SEG_RESET;
        end else if (i_cfg_we) begin
            r_segments <= i_cfg_data;
        end
    end

    // restoring division of 2^T by the segment count, one quotient bit a cycle
    always_comb begin
        n_shift = {r_rem, (r_bit == CNT_W'(T))};
        n_ge    = (n_shift >= {1'b0, r_segs_eff});
        n_rem   = n_ge ? SEG_W'(n_shift - {1'b0, r_segs_eff}) : n_shift[SEG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ctl.valid) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit == '0) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.valid) begin
            r_ctl[0][0] <= i_ctl.p0_x;
            r_ctl[0][1] <= i_ctl.p0_y;
            r_ctl[0][2] <= i_ctl.p0_z;
            r_ctl[1][0] <= i_ctl.p1_x;
            r_ctl[1][1] <= i_ctl.p1_y;
            r_ctl[1][2] <= i_ctl.p1_z;
            r_ctl[2][0] <= i_ctl.p2_x;
            r_ctl[2][1] <= i_ctl.p2_y;
            r_ctl[2][2] <= i_ctl.p2_z;
            r_ctl[3][0] <= i_ctl.p3_x;
            r_ctl[3][1] <= i_ctl.p3_y;
            r_ctl[3][2] <= i_ctl.p3_z;
            // zero segments behaves as one
            r_segs_eff  <= (r_segments == '0) ? SEG_W'(1) : r_segments;
            r_bit       <= CNT_W'(T);
            r_rem       <= '0;
            r_quo       <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[T-1:0], n_ge};
            r_bit <= r_bit - CNT_W'(1);
        end
    end

    always_comb begin
        job_out.ctl    = r_ctl;
        job_out.segs   = r_segs_eff;
        job_out.q_step = r_quo;
        job_out.r_step = r_rem;
    end

    assign o_job = job_out;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_segs_eff))
        else $error("partial remainder not below segment count");

    a_segs_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> (r_segs_eff != '0))
        else $error("job carries zero segments");
`endif

endmodule

// File: hw/rtl/cbt_queue.sv
module cbt_queue import cbt_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [0:Q_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/cbt_back.sv
module cbt_back import cbt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_job_valid,
    output logic                                          o_job_ready,
    input  logic [f_job_w(COORD_WIDTH, T_FRAC_BITS)-1:0]  i_job,
    cbt_curve_if.source                                   o_curve
);

    localparam int C  = COORD_WIDTH;
    localparam int T  = T_FRAC_BITS;
    localparam int PW = C + T + 1;

    localparam logic signed [PW-1:0] SAT_HI = {{(PW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = {{(PW-C+1){1'b1}}, {(C-1){1'b0}}};
    localparam logic [T:0]           T_ONE  = {1'b1, {T{1'b0}}};

    typedef logic signed [C-1:0]  t_coord;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        logic [3:0][2:0][C-1:0] ctl;
        logic [SEG_W-1:0]       segs;
        logic [T:0]             q_step;
        logic [SEG_W-1:0]       r_step;
    } t_job;

    // t * (q - p), exact
    function automatic t_prod f_mul(input logic [T:0] t_in, input t_coord p, input t_coord q);
        logic signed [C:0] diff;
        t_prod             ta;
        t_prod             da;
        diff = {q[C-1], q} - {p[C-1], p};
        ta   = {{(PW-T-1){1'b0}}, t_in};
        da   = {{(PW-C-1){diff[C]}}, diff};
        return ta * da;
    endfunction

    // p + floor(prod / 2^T), saturated
    function automatic t_coord f_lerp(input t_coord p, input t_prod prod);
        t_prod s;
        s = $signed({{(PW-C){p[C-1]}}, p}) + (prod >>> T);
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[C-1:0];
    endfunction

    // point sequencer
    t_job             r_job;
    logic             r_busy;
    logic [SEG_W-1:0] r_i;
    logic [SEG_W-1:0] r_rem;
    logic [T:0]       r_t;

    logic             adv;
    logic             issue;
    logic             is_last;
    logic             pop;
    logic [SEG_W:0]   n_rem_sum;
    logic             n_carry;
    logic [SEG_W-1:0] n_rem;
    logic [T:0]       n_t;

    // interpolation pipeline: multiply and add stages for each of the three rounds
    logic       r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic       r_s1_last, r_s2_last, r_s3_last, r_s4_last, r_s5_last, r_s6_last;
    logic [T:0] r_s1_t, r_s2_t, r_s3_t, r_s4_t;
    t_coord     r_s1_p [0:2][0:2];
    t_prod      r_s1_m [0:2][0:2];
    t_coord     r_s2_w [0:2][0:2];
    t_coord     r_s3_p [0:2][0:1];
    t_prod      r_s3_m [0:2][0:1];
    t_coord     r_s4_w [0:2][0:1];
    t_coord     r_s5_p [0:2];
    t_prod      r_s5_m [0:2];
    t_coord     r_s6_w [0:2];

    always_comb begin
        adv       = !r_s6_vld || o_curve.ready;
        issue     = r_busy && adv;
        is_last   = (r_i == r_job.segs);
        pop       = i_job_valid && (!r_busy || (issue && is_last));
        // t advances by the quotient, plus one whenever the remainder wraps
        n_rem_sum = {1'b0, r_rem} + {1'b0, r_job.r_step};
        n_carry   = (n_rem_sum >= {1'b0, r_job.segs});
        n_rem     = n_carry ? SEG_W'(n_rem_sum - {1'b0, r_job.segs})
                            : n_rem_sum[SEG_W-1:0];
        n_t       = r_t + r_job.q_step + (T+1)'(n_carry);
    end

    assign o_job_ready = (!r_busy || (issue && is_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (pop) begin
            r_busy <= 1'b1;
        end else if (issue && is_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= t_job'(i_job);
            r_i   <= '0;
            r_t   <= '0;
            r_rem <= '0;
        end else if (issue) begin
            r_i   <= r_i + SEG_W'(1);
            r_t   <= n_t;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= r_busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_last <= is_last;
            r_s1_t    <= r_t;
            r_s2_last <= r_s1_last;
            r_s2_t    <= r_s1_t;
            r_s3_last <= r_s2_last;
            r_s3_t    <= r_s2_t;
            r_s4_last <= r_s3_last;
            r_s4_t    <= r_s3_t;
            r_s5_last <= r_s4_last;
            r_s6_last <= r_s5_last;
            for (int ax = 0; ax < 3; ax++) begin
                for (int k = 0; k < 3; k++) begin
                    r_s1_p[ax][k] <= r_job.ctl[k][ax];
                    r_s1_m[ax][k] <= f_mul(r_t, r_job.ctl[k][ax], r_job.ctl[k+1][ax]);
                    r_s2_w[ax][k] <= f_lerp(r_s1_p[ax][k], r_s1_m[ax][k]);
                end
                for (int k = 0; k < 2; k++) begin
                    r_s3_p[ax][k] <= r_s2_w[ax][k];
                    r_s3_m[ax][k] <= f_mul(r_s2_t, r_s2_w[ax][k], r_s2_w[ax][k+1]);
                    r_s4_w[ax][k] <= f_lerp(r_s3_p[ax][k], r_s3_m[ax][k]);
                end
                r_s5_p[ax] <= r_s4_w[ax][0];
                r_s5_m[ax] <= f_mul(r_s4_t, r_s4_w[ax][0], r_s4_w[ax][1]);
                r_s6_w[ax] <= f_lerp(r_s5_p[ax], r_s5_m[ax]);
            end
        end
    end

    assign o_curve.valid      = r_s6_vld;
    assign o_curve.curve_x    = r_s6_w[0];
    assign o_curve.curve_y    = r_s6_w[1];
    assign o_curve.curve_z    = r_s6_w[2];
    assign o_curve.last_point = r_s6_last;

`ifndef SYNTH
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_i <= r_job.segs))
        else $error("point index beyond segment count");

    a_t_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_i == '0) |-> (r_t == '0))
        else $error("first point of a segment has nonzero t");

    a_t_ends_at_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && is_last) |-> (r_t == T_ONE))
        else $error("final point of a segment has t other than one");
`endif

endmodule

// File: hw/rtl/cubic_bezier_tessellator.sv
// Cubic Bezier tessellator. Each transfer on i_ctl carries four signed control points
// (x, y, z each); the block returns segments+1 curve points on o_curve at t = i/segments,
// computed by de Casteljau interpolation with floor rounding and saturation, and flags the
// final point with last_point. The segment count is written through i_cfg_we/i_cfg_data
// (reset 20, zero acts as one) and is sampled when a segment is taken in. Points leave at
// one per cycle while o_curve.ready is high and a job is waiting, paced by the point
// sequencer of the back end. The bit-serial t-step divider of the front end works on the
// next segment while the back end emits the current one. A segment passes from the
// front-end divider through the job queue into the interpolation pipeline of the back end.
module cubic_bezier_tessellator import cbt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SEG_W-1:0] i_cfg_data,
    cbt_ctl_if.sink          i_ctl,
    cbt_curve_if.source      o_curve
);

    localparam int JOB_W = f_job_w(COORD_WIDTH, T_FRAC_BITS);

    logic             front_valid;
    logic             front_ready;
    logic [JOB_W-1:0] front_job;
    logic             back_valid;
    logic             back_ready;
    logic [JOB_W-1:0] back_job;

    cbt_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (i_ctl),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    cbt_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_job)
    );

    cbt_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_curve     (o_curve)
    );

endmodule
